// File: hw/rtl/aga_pkg.sv
// Shared types and constants of the affine-gap global aligner.
`default_nettype none
package aga_pkg;

    localparam int OPC_W     = 2;
    localparam int SYM_W     = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int RUN_W     = 7;
    localparam int TOTAL_W   = 18;

    // Input opcodes
    localparam logic [OPC_W-1:0] OPC_TARGET = 2'd0;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_ALIGN  = 2'd2;

    // CIGAR operation codes
    localparam logic [OP_W-1:0] CIG_EQ  = 2'd0;
    localparam logic [OP_W-1:0] CIG_SUB = 2'd1;
    localparam logic [OP_W-1:0] CIG_INS = 2'd2;
    localparam logic [OP_W-1:0] CIG_DEL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = 2'd3;

    typedef struct packed {
        logic signed [CFG_W-1:0] match;
        logic signed [CFG_W-1:0] mismatch;
        logic signed [CFG_W-1:0] gopen;
        logic signed [CFG_W-1:0] gap_ext;
    } score_cfg_t;

    // Traceback bits kept for every table cell
    typedef struct packed {
        logic            eq;
        logic            iopen;
        logic            dopen;
        logic [OP_W-1:0] gen_op;
    } tie_t;

    // Request that starts the run-length emitter
    typedef struct packed {
        logic             start;
        logic [RUN_W-1:0] cnt;
        logic [OP_W-1:0]  op;
        logic [RUN_W-1:0] len;
    } emit_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/aga_if.sv
// Valid/ready channel interfaces for the command and result streams.
`default_nettype none
interface aga_in_if;
    import aga_pkg::*;
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [SYM_W-1:0] symbol;
    modport source (output valid, opcode, symbol, input ready);
    modport sink (input valid, opcode, symbol, output ready);
endinterface

interface aga_out_if;
    import aga_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           cigar_op;
    logic [RUN_W-1:0]          run_length;
    logic signed [TOTAL_W-1:0] total_score;
    logic                      overflow;
    logic                      last;
    modport source (output valid, cigar_op, run_length, total_score, overflow, last,
                    input ready);
    modport sink (input valid, cigar_op, run_length, total_score, overflow, last,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/aga_cell.sv
// One column cell of the systolic score row with its traceback bit store.
`default_nettype none
module aga_cell #(
    parameter int MAX_LEN = 32,
    parameter int SCORE_W = 18,
    parameter int COL     = 0,
    parameter int ROW_W   = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          init,
    input  logic signed [SCORE_W-1:0]     inf_val,
    input  aga_pkg::score_cfg_t           cfg,
    input  logic                          q_load,
    input  logic [aga_pkg::SYM_W-1:0]     q_sym,
    input  logic                          in_valid,
    input  logic [aga_pkg::SYM_W-1:0]     in_sym,
    input  logic [ROW_W-1:0]              in_row,
    input  logic signed [SCORE_W-1:0]     in_m,
    input  logic signed [SCORE_W-1:0]     in_i,
    input  logic signed [SCORE_W-1:0]     in_dm,
    input  logic signed [SCORE_W-1:0]     in_di,
    input  logic signed [SCORE_W-1:0]     in_dd,
    output logic                          out_valid,
    output logic [aga_pkg::SYM_W-1:0]     out_sym,
    output logic [ROW_W-1:0]              out_row,
    output logic signed [SCORE_W-1:0]     out_m,
    output logic signed [SCORE_W-1:0]     out_i,
    output logic signed [SCORE_W-1:0]     out_dm,
    output logic signed [SCORE_W-1:0]     out_di,
    output logic signed [SCORE_W-1:0]     out_dd,
    output logic signed [SCORE_W-1:0]     m_val,
    output logic signed [SCORE_W-1:0]     i_val,
    output logic signed [SCORE_W-1:0]     d_val,
    input  logic [ROW_W-1:0]              rd_row,
    output aga_pkg::tie_t                 rd_bits
);
    import aga_pkg::*;

    logic [SYM_W-1:0]          q_sym_reg;
    logic signed [SCORE_W-1:0] m_reg, i_reg, d_reg;
    logic                      out_valid_reg;
    logic [SYM_W-1:0]          out_sym_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic signed [SCORE_W-1:0] out_m_reg, out_i_reg, out_dm_reg, out_di_reg, out_dd_reg;
    tie_t                      tie_mem [0:MAX_LEN-1];
    tie_t                      rd_bits_reg;

    logic signed [SCORE_W-1:0] go, ge, diag_best, add, m_new;
    logic signed [SCORE_W-1:0] i_open, i_ext, i_new, d_open, d_ext, d_new;
    logic                      sym_eq, i_from_open, d_from_open;
    logic [OP_W-1:0]           pair_op;
    tie_t                      tie_new;

    // Cell recurrence for one row of this column
    always_comb
    begin
        go          = SCORE_W'(cfg.gopen);
        ge          = SCORE_W'(cfg.gap_ext);
        diag_best   = (in_dm > in_di) ? in_dm : in_di;
        diag_best   = (diag_best > in_dd) ? diag_best : in_dd;
        sym_eq      = (in_sym == q_sym_reg);
        add         = sym_eq ? SCORE_W'(cfg.match) : SCORE_W'(cfg.mismatch);
        m_new       = diag_best + add;
        i_open      = in_m + go;
        i_ext       = in_i + ge;
        i_from_open = (i_open >= i_ext);
        i_new       = i_from_open ? i_open : i_ext;
        d_open      = m_reg + go;
        d_ext       = d_reg + ge;
        d_from_open = (d_open >= d_ext);
        d_new       = d_from_open ? d_open : d_ext;
        pair_op     = sym_eq ? CIG_EQ : CIG_SUB;
        tie_new.eq    = sym_eq;
        tie_new.iopen = i_from_open;
        tie_new.dopen = d_from_open;
        if (m_new >= d_new)
        begin
            tie_new.gen_op = (m_new >= i_new) ? pair_op : CIG_INS;
        end
        else
        begin
            tie_new.gen_op = (d_new >= i_new) ? CIG_DEL : CIG_INS;
        end
    end

    // Hold the query symbol of this column
    always_ff @(posedge clk)
    begin
        if (q_load)
        begin
            q_sym_reg <= q_sym;
        end
    end

    // Advance the column scores; load the top-row boundary on init
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            m_reg <= inf_val;
            d_reg <= inf_val;
            i_reg <= go + $signed(SCORE_W'(COL)) * ge;
        end
        else if (in_valid)
        begin
            m_reg <= m_new;
            i_reg <= i_new;
            d_reg <= d_new;
        end
    end

    // Hand data to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid && !init;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sym_reg <= in_sym;
        out_row_reg <= in_row;
        out_m_reg   <= m_new;
        out_i_reg   <= i_new;
        out_dm_reg  <= m_reg;
        out_di_reg  <= i_reg;
        out_dd_reg  <= d_reg;
    end

    // Store traceback bits per row and read them back for the walk
    always_ff @(posedge clk)
    begin
        if (in_valid && !init)
        begin
            tie_mem[in_row] <= tie_new;
        end
        rd_bits_reg <= tie_mem[rd_row];
    end

    assign out_valid = out_valid_reg;
    assign out_sym   = out_sym_reg;
    assign out_row   = out_row_reg;
    assign out_m     = out_m_reg;
    assign out_i     = out_i_reg;
    assign out_dm    = out_dm_reg;
    assign out_di    = out_di_reg;
    assign out_dd    = out_dd_reg;
    assign m_val     = m_reg;
    assign i_val     = i_reg;
    assign d_val     = d_reg;
    assign rd_bits   = rd_bits_reg;

endmodule
`default_nettype wire

// File: hw/rtl/aga_emit.sv
// Path buffer and run-length emitter that replays the traceback in forward order.
`default_nettype none
module aga_emit #(
    parameter int MAX_LEN = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  aga_pkg::emit_req_t                 req,
    input  logic signed [aga_pkg::TOTAL_W-1:0] score,
    input  logic                               ovf,
    input  logic                               path_we,
    input  logic [aga_pkg::RUN_W-1:0]          path_addr,
    input  logic [aga_pkg::OP_W-1:0]           path_op,
    output logic                               busy,
    aga_out_if.source                          result
);
    import aga_pkg::*;

    localparam int PATH_D = 2 * MAX_LEN;
    localparam int PATH_W = $clog2(PATH_D);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_READ  = 4'b0010,
        E_CMP   = 4'b0100,
        E_FINAL = 4'b1000
    } emit_state_t;

    emit_state_t               state_reg, state_next;
    logic [OP_W-1:0]           path_mem [0:PATH_D-1];
    logic [RUN_W-1:0]          idx_reg, idx_next, len_reg, len_next, rd_idx;
    logic [OP_W-1:0]           cur_op_reg, cur_op_next, rd_op_reg;
    logic signed [TOTAL_W-1:0] score_reg;
    logic                      ovf_reg;
    logic                      out_valid_reg;
    logic [OP_W-1:0]           out_op_reg;
    logic [RUN_W-1:0]          out_len_reg;
    logic signed [TOTAL_W-1:0] out_score_reg;
    logic                      out_ovf_reg, out_last_reg;
    logic                      slot_free, push, push_last, need_push;

    assign slot_free = !out_valid_reg || result.ready;
    assign rd_idx    = idx_reg - RUN_W'(1);
    assign need_push = (len_reg != '0) && (rd_op_reg != cur_op_reg);

    // Walk the path from its far end, merging equal operations into runs
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        cur_op_next = cur_op_reg;
        push        = 1'b0;
        push_last   = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    idx_next    = req.cnt;
                    len_next    = req.len;
                    cur_op_next = req.op;
                    state_next  = (req.cnt == '0) ? E_FINAL : E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_CMP;
            end
            E_CMP:
            begin
                if (!need_push || slot_free)
                begin
                    push        = need_push;
                    len_next    = need_push ? RUN_W'(1) : len_reg + RUN_W'(1);
                    cur_op_next = rd_op_reg;
                    idx_next    = rd_idx;
                    state_next  = (rd_idx == '0) ? E_FINAL : E_READ;
                end
            end
            E_FINAL:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch run data, score and overflow for the whole alignment
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        cur_op_reg <= cur_op_next;
        if (state_reg == E_IDLE && req.start)
        begin
            score_reg <= score;
            ovf_reg   <= ovf;
        end
        if (push)
        begin
            out_op_reg    <= cur_op_reg;
            out_len_reg   <= len_reg;
            out_score_reg <= score_reg;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= push_last;
        end
    end

    // Path store: written by the traceback, read backward here
    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_addr[PATH_W-1:0]] <= path_op;
        end
        if (state_reg == E_READ)
        begin
            rd_op_reg <= path_mem[rd_idx[PATH_W-1:0]];
        end
    end

    assign busy               = (state_reg != E_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.cigar_op    = out_op_reg;
    assign result.run_length  = out_len_reg;
    assign result.total_score = out_score_reg;
    assign result.overflow    = out_ovf_reg;
    assign result.last        = out_last_reg;

endmodule
`default_nettype wire

// File: hw/rtl/affine_gap_global_aligner.sv
// Affine-gap global aligner: systolic score row over the query, traceback and CIGAR output.
// Append items can be accepted every cycle while the control sequence is idle.
// An align item passes setup (S_INIT, S_PRIME), the sweep of the target rows through the cell
// row, the final score (S_FIN) and the traceback walk (S_TB_RD, S_TB_ST per step, target+query
// steps at most), then the emitter replays the path as runs, stalling while the result side does.
// Reset clears lengths, overflow flag and scores to defaults; stores need no clearing pass.
`default_nettype none
module affine_gap_global_aligner #(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    aga_in_if.sink                           cmd,
    aga_out_if.source                        result,
    input  logic                             cfg_wr_en,
    input  logic [aga_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [aga_pkg::CFG_W-1:0]        cfg_wdata
);
    import aga_pkg::*;

    localparam int SCORE_W = SCORE_WIDTH;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ROW_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_PRIME = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_TB_RD = 7'b0100000,
        S_TB_ST = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          tlen_reg, tlen_next, qlen_reg, qlen_next;
    logic                      ovf_reg, ovf_next;
    score_cfg_t                cfg_reg;
    logic signed [SCORE_W-1:0] inf_reg, inf_next, empty_score_reg, empty_score_next;
    logic [CNT_W-1:0]          feed_row_reg, feed_row_next;
    logic                      fd_valid_reg, fd_valid_next;
    logic [ROW_W-1:0]          fd_row_reg, fd_row_next;
    logic [SYM_W-1:0]          tgt_q_reg;
    logic [SYM_W-1:0]          tgt_mem [0:MAX_LEN-1];
    logic signed [SCORE_W-1:0] prev_m_reg, prev_m_next, prev_i_reg, prev_i_next;
    logic signed [SCORE_W-1:0] prev_d_reg, prev_d_next, dcol_reg, dcol_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [CNT_W-1:0]          tb_i_reg, tb_i_next, tb_j_reg, tb_j_next;
    logic [OP_W-1:0]           st_op_reg, st_op_next;
    logic                      st_start_reg, st_start_next;
    logic                      prev_iopen_reg, prev_iopen_next;
    logic                      prev_dopen_reg, prev_dopen_next;
    logic [RUN_W-1:0]          n_reg, n_next;

    // Cell row links: entry 0 is the boundary feeder, entry c+1 leaves cell c
    logic                      ch_valid [0:MAX_LEN];
    logic [SYM_W-1:0]          ch_sym   [0:MAX_LEN];
    logic [ROW_W-1:0]          ch_row   [0:MAX_LEN];
    logic signed [SCORE_W-1:0] ch_m     [0:MAX_LEN];
    logic signed [SCORE_W-1:0] ch_i     [0:MAX_LEN];
    logic signed [SCORE_W-1:0] ch_dm    [0:MAX_LEN];
    logic signed [SCORE_W-1:0] ch_di    [0:MAX_LEN];
    logic signed [SCORE_W-1:0] ch_dd    [0:MAX_LEN];
    logic signed [SCORE_W-1:0] cell_m   [0:MAX_LEN-1];
    logic signed [SCORE_W-1:0] cell_i   [0:MAX_LEN-1];
    logic signed [SCORE_W-1:0] cell_d   [0:MAX_LEN-1];
    tie_t                      cell_bits [0:MAX_LEN-1];

    logic                      in_ready, acc, tgt_we, qry_we, cell_init;
    logic [CNT_W-1:0]          tlen_m1, qlen_m1, tb_im1, tb_jm1, len_max;
    logic [ROW_W-1:0]          qm1, tlm1, rd_row, jm1;
    logic [RUN_W-1:0]          empty_len;
    logic signed [CFG_W-1:0]   mn;
    logic                      feed_issue, fill_done;
    logic signed [SCORE_W-1:0] fm, fi, fd, fmax;
    tie_t                      bits;
    logic [OP_W-1:0]           pair_op, tb_op;
    logic                      tb_done;
    emit_req_t                 req;
    logic                      path_we, emit_busy;

    assign in_ready  = (state_reg == S_IDLE) && (!emit_busy || cmd.opcode != OPC_ALIGN);
    assign cmd.ready = in_ready;
    assign acc       = cmd.valid && in_ready;
    assign tgt_we    = acc && cmd.opcode == OPC_TARGET && tlen_reg < CNT_W'(MAX_LEN);
    assign qry_we    = acc && cmd.opcode == OPC_QUERY && qlen_reg < CNT_W'(MAX_LEN);
    assign cell_init = (state_reg == S_PRIME);

    assign tlen_m1   = tlen_reg - CNT_W'(1);
    assign qlen_m1   = qlen_reg - CNT_W'(1);
    assign tlm1      = tlen_m1[ROW_W-1:0];
    assign qm1       = qlen_m1[ROW_W-1:0];
    assign tb_im1    = tb_i_reg - CNT_W'(1);
    assign tb_jm1    = tb_j_reg - CNT_W'(1);
    assign rd_row    = tb_im1[ROW_W-1:0];
    assign jm1       = tb_jm1[ROW_W-1:0];
    assign len_max   = (tlen_reg > qlen_reg) ? tlen_reg : qlen_reg;
    assign empty_len = RUN_W'(tlen_reg) + RUN_W'(qlen_reg);
    assign mn        = (cfg_reg.mismatch < cfg_reg.gopen) ? cfg_reg.mismatch
                                                          : cfg_reg.gopen;
    assign feed_issue = (state_reg == S_FILL) && (feed_row_reg < tlen_reg);
    assign fill_done  = ch_valid[qm1] && (ch_row[qm1] == tlm1);

    // Final cell scores and traceback bits of the current cell
    assign fm      = cell_m[qm1];
    assign fi      = cell_i[qm1];
    assign fd      = cell_d[qm1];
    assign fmax    = ((fm > fi) ? fm : fi) > fd ? ((fm > fi) ? fm : fi) : fd;
    assign bits    = cell_bits[jm1];
    assign pair_op = bits.eq ? CIG_EQ : CIG_SUB;

    // Pick the traceback step under the state-dependent tie rules
    always_comb
    begin
        if (tb_i_reg == '0)
        begin
            tb_op = CIG_INS;
        end
        else if (tb_j_reg == '0)
        begin
            tb_op = CIG_DEL;
        end
        else if (!st_start_reg && st_op_reg == CIG_DEL)
        begin
            tb_op = prev_dopen_reg ? pair_op : CIG_DEL;
        end
        else if (!st_start_reg && st_op_reg == CIG_INS)
        begin
            tb_op = prev_iopen_reg ? pair_op : CIG_INS;
        end
        else
        begin
            tb_op = bits.gen_op;
        end
    end

    // Control sequence: load, set up, sweep, walk back, hand off
    always_comb
    begin
        state_next       = state_reg;
        tlen_next        = tlen_reg;
        qlen_next        = qlen_reg;
        ovf_next         = ovf_reg;
        inf_next         = inf_reg;
        empty_score_next = empty_score_reg;
        feed_row_next    = feed_row_reg;
        fd_valid_next    = feed_issue;
        fd_row_next      = feed_row_reg[ROW_W-1:0];
        prev_m_next      = prev_m_reg;
        prev_i_next      = prev_i_reg;
        prev_d_next      = prev_d_reg;
        dcol_next        = dcol_reg;
        score_next       = score_reg;
        tb_i_next        = tb_i_reg;
        tb_j_next        = tb_j_reg;
        st_op_next       = st_op_reg;
        st_start_next    = st_start_reg;
        prev_iopen_next  = prev_iopen_reg;
        prev_dopen_next  = prev_dopen_reg;
        n_next           = n_reg;
        tb_done          = 1'b0;
        path_we          = 1'b0;
        req              = '0;

        // Advance the column-zero boundary as each row enters cell 0
        if (fd_valid_reg)
        begin
            prev_m_next = inf_reg;
            prev_i_next = inf_reg;
            prev_d_next = dcol_reg;
            dcol_next   = dcol_reg + SCORE_W'(cfg_reg.gap_ext);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (cmd.opcode)
                        OPC_TARGET:
                        begin
                            if (tgt_we)
                            begin
                                tlen_next = tlen_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OPC_QUERY:
                        begin
                            if (qry_we)
                            begin
                                qlen_next = qlen_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OPC_ALIGN:
                        begin
                            state_next = S_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                inf_next = $signed(SCORE_W'(mn)) * $signed(SCORE_W'(len_max + CNT_W'(1)));
                empty_score_next = $signed(SCORE_W'(cfg_reg.gopen))
                                 + $signed(SCORE_W'(empty_len - RUN_W'(1)))
                                 * $signed(SCORE_W'(cfg_reg.gap_ext));
                state_next = S_PRIME;
            end
            S_PRIME:
            begin
                if (tlen_reg == '0 || qlen_reg == '0)
                begin
                    req.start  = 1'b1;
                    req.cnt    = '0;
                    req.len    = empty_len;
                    req.op     = (tlen_reg != '0) ? CIG_DEL
                               : ((qlen_reg != '0) ? CIG_INS : CIG_EQ);
                    score_next = (empty_len == '0) ? '0 : empty_score_reg;
                    tlen_next  = '0;
                    qlen_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    feed_row_next = '0;
                    prev_m_next   = '0;
                    prev_i_next   = '0;
                    prev_d_next   = '0;
                    dcol_next     = SCORE_W'(cfg_reg.gopen);
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                if (feed_issue)
                begin
                    feed_row_next = feed_row_reg + CNT_W'(1);
                end
                if (fill_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                score_next    = fmax;
                tb_i_next     = tlen_reg;
                tb_j_next     = qlen_reg;
                st_start_next = 1'b1;
                n_next        = '0;
                state_next    = S_TB_RD;
            end
            S_TB_RD:
            begin
                state_next = S_TB_ST;
            end
            S_TB_ST:
            begin
                path_we         = 1'b1;
                n_next          = n_reg + RUN_W'(1);
                st_op_next      = tb_op;
                st_start_next   = 1'b0;
                prev_iopen_next = bits.iopen;
                prev_dopen_next = bits.dopen;
                if (tb_op != CIG_DEL)
                begin
                    tb_j_next = tb_jm1;
                end
                if (tb_op != CIG_INS)
                begin
                    tb_i_next = tb_im1;
                end
                tb_done = (tb_i_next == '0) && (tb_j_next == '0);
                if (tb_done)
                begin
                    req.start  = 1'b1;
                    req.cnt    = n_next;
                    req.len    = '0;
                    req.op     = CIG_EQ;
                    tlen_next  = '0;
                    qlen_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TB_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and score configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tlen_reg         <= '0;
            qlen_reg         <= '0;
            ovf_reg          <= 1'b0;
            fd_valid_reg     <= 1'b0;
            cfg_reg.match    <= 8'sd1;
            cfg_reg.mismatch <= -8'sd4;
            cfg_reg.gopen    <= -8'sd6;
            cfg_reg.gap_ext  <= -8'sd1;
        end
        else
        begin
            state_reg    <= state_next;
            tlen_reg     <= tlen_next;
            qlen_reg     <= qlen_next;
            ovf_reg      <= ovf_next;
            fd_valid_reg <= fd_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_MATCH:    cfg_reg.match    <= cfg_wdata;
                    REG_MISMATCH: cfg_reg.mismatch <= cfg_wdata;
                    REG_GAP_OPEN: cfg_reg.gopen    <= cfg_wdata;
                    REG_GAP_EXT:  cfg_reg.gap_ext  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        inf_reg         <= inf_next;
        empty_score_reg <= empty_score_next;
        feed_row_reg    <= feed_row_next;
        fd_row_reg      <= fd_row_next;
        prev_m_reg      <= prev_m_next;
        prev_i_reg      <= prev_i_next;
        prev_d_reg      <= prev_d_next;
        dcol_reg        <= dcol_next;
        score_reg       <= score_next;
        tb_i_reg        <= tb_i_next;
        tb_j_reg        <= tb_j_next;
        st_op_reg       <= st_op_next;
        st_start_reg    <= st_start_next;
        prev_iopen_reg  <= prev_iopen_next;
        prev_dopen_reg  <= prev_dopen_next;
        n_reg           <= n_next;
    end

    // Target store: append on load, stream out row by row during the sweep
    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tlen_reg[ROW_W-1:0]] <= cmd.symbol;
        end
        tgt_q_reg <= tgt_mem[feed_row_reg[ROW_W-1:0]];
    end

    // Boundary feeder into cell 0
    assign ch_valid[0] = fd_valid_reg;
    assign ch_sym[0]   = tgt_q_reg;
    assign ch_row[0]   = fd_row_reg;
    assign ch_m[0]     = inf_reg;
    assign ch_i[0]     = inf_reg;
    assign ch_dm[0]    = prev_m_reg;
    assign ch_di[0]    = prev_i_reg;
    assign ch_dd[0]    = prev_d_reg;

    // Row of cells, one per query position
    for (genvar c = 0; c < MAX_LEN; c++)
    begin : g_cell
        logic q_load;
        assign q_load = qry_we && (qlen_reg[ROW_W-1:0] == ROW_W'(c));

        aga_cell #(
            .MAX_LEN (MAX_LEN),
            .SCORE_W (SCORE_W),
            .COL     (c),
            .ROW_W   (ROW_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .init      (cell_init),
            .inf_val   (inf_reg),
            .cfg       (cfg_reg),
            .q_load    (q_load),
            .q_sym     (cmd.symbol),
            .in_valid  (ch_valid[c]),
            .in_sym    (ch_sym[c]),
            .in_row    (ch_row[c]),
            .in_m      (ch_m[c]),
            .in_i      (ch_i[c]),
            .in_dm     (ch_dm[c]),
            .in_di     (ch_di[c]),
            .in_dd     (ch_dd[c]),
            .out_valid (ch_valid[c+1]),
            .out_sym   (ch_sym[c+1]),
            .out_row   (ch_row[c+1]),
            .out_m     (ch_m[c+1]),
            .out_i     (ch_i[c+1]),
            .out_dm    (ch_dm[c+1]),
            .out_di    (ch_di[c+1]),
            .out_dd    (ch_dd[c+1]),
            .m_val     (cell_m[c]),
            .i_val     (cell_i[c]),
            .d_val     (cell_d[c]),
            .rd_row    (rd_row),
            .rd_bits   (cell_bits[c])
        );
    end

    // Path buffer and run-length output
    aga_emit #(
        .MAX_LEN (MAX_LEN)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .score     (TOTAL_W'(score_next)),
        .ovf       (ovf_reg),
        .path_we   (path_we),
        .path_addr (n_reg),
        .path_op   (tb_op),
        .busy      (emit_busy),
        .result    (result)
    );

endmodule
`default_nettype wire

// File: test/aga_checker.sv
// Result checker for the affine-gap aligner: watches the channels and predicts CIGAR runs.
`timescale 1ns / 100ps
`default_nettype none
module aga_checker
    import aga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    aga_in_if                    cmd,
    aga_out_if                   result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   errors,
    output int                   pending
);
    localparam int MAXL = 32;
    localparam logic [2:0] TRACE_START = 3'd4;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [RUN_W-1:0]   len;
        logic [TOTAL_W-1:0] score;
        logic               ovf;
        logic               last;
    } cigar_run_t;

    cigar_run_t run_q[$];

    logic [SYM_W-1:0] tgt_seq[MAXL];
    logic [SYM_W-1:0] qry_seq[MAXL];
    int tgt_len, qry_len;
    logic ovf_flag;
    int sc_match, sc_mis, sc_open, sc_ext;
    int tm[MAXL+1][MAXL+1];
    int ti[MAXL+1][MAXL+1];
    int td[MAXL+1][MAXL+1];
    logic [OP_W-1:0] path[2*MAXL];

    function automatic int imax(int a, int b);
        return a > b ? a : b;
    endfunction

    function automatic logic [OP_W-1:0] pair_kind(int i, int j);
        return tgt_seq[i-1] == qry_seq[j-1] ? CIG_EQ : CIG_SUB;
    endfunction

    // Pick the traceback step for cell (i, j) given the previous step
    function automatic logic [2:0] trace_step(int i, int j, logic [2:0] st);
        int m;
        m = tm[i][j];
        if (i == 0) return {1'b0, CIG_INS};
        if (j == 0) return {1'b0, CIG_DEL};
        if (st == {1'b0, CIG_DEL}) begin
            if (i < MAXL && td[i+1][j] == m + sc_open) return {1'b0, pair_kind(i, j)};
            return {1'b0, CIG_DEL};
        end
        if (st == {1'b0, CIG_INS}) begin
            if (j < MAXL && ti[i][j+1] == m + sc_open) return {1'b0, pair_kind(i, j)};
            return {1'b0, CIG_INS};
        end
        if (m >= td[i][j]) return m >= ti[i][j] ? {1'b0, pair_kind(i, j)} : {1'b0, CIG_INS};
        return td[i][j] >= ti[i][j] ? {1'b0, CIG_DEL} : {1'b0, CIG_INS};
    endfunction

    function automatic void push_run(logic [OP_W-1:0] op, int len, int score, logic last);
        cigar_run_t r;
        r.op    = op;
        r.len   = len[RUN_W-1:0];
        r.score = score[TOTAL_W-1:0];
        r.ovf   = ovf_flag;
        r.last  = last;
        run_q.push_back(r);
    endfunction

    // Fill the three score tables, trace back and queue the CIGAR runs
    function automatic void align_runs();
        int inf, mn, score, i, j, n, len;
        logic [2:0] st;
        logic [OP_W-1:0] op;
        if (tgt_len == 0 || qry_len == 0) begin
            len = tgt_len + qry_len;
            if (len == 0)
                push_run(CIG_EQ, 0, 0, 1'b1);
            else
                push_run(tgt_len == 0 ? CIG_INS : CIG_DEL, len,
                         sc_open + (len - 1) * sc_ext, 1'b1);
            return;
        end
        mn = sc_mis < sc_open ? sc_mis : sc_open;
        inf = mn * (imax(tgt_len, qry_len) + 1);
        tm[0][0] = 0;
        ti[0][0] = 0;
        td[0][0] = 0;
        for (i = 1; i <= tgt_len; i++) begin
            tm[i][0] = inf;
            ti[i][0] = inf;
            td[i][0] = sc_open + (i - 1) * sc_ext;
        end
        for (j = 1; j <= qry_len; j++) begin
            tm[0][j] = inf;
            td[0][j] = inf;
            ti[0][j] = sc_open + (j - 1) * sc_ext;
        end
        for (i = 1; i <= tgt_len; i++)
            for (j = 1; j <= qry_len; j++) begin
                tm[i][j] = imax(imax(tm[i-1][j-1], ti[i-1][j-1]), td[i-1][j-1])
                         + (tgt_seq[i-1] == qry_seq[j-1] ? sc_match : sc_mis);
                ti[i][j] = imax(ti[i][j-1] + sc_ext, tm[i][j-1] + sc_open);
                td[i][j] = imax(td[i-1][j] + sc_ext, tm[i-1][j] + sc_open);
            end
        score = imax(imax(tm[tgt_len][qry_len], ti[tgt_len][qry_len]),
                     td[tgt_len][qry_len]);
        st = TRACE_START;
        i = tgt_len;
        j = qry_len;
        n = 0;
        while ((i > 0 || j > 0) && n < 2 * MAXL) begin
            st = trace_step(i, j, st);
            path[n++] = st[OP_W-1:0];
            if (st[OP_W-1:0] == CIG_EQ || st[OP_W-1:0] == CIG_SUB) begin
                i--;
                j--;
            end else if (st[OP_W-1:0] == CIG_INS) j--;
            else i--;
        end
        // Merge the reversed path into forward runs
        while (n > 0) begin
            op = path[n-1];
            len = 0;
            while (n > 0 && path[n-1] == op) begin
                n--;
                len++;
            end
            push_run(op, len, score, n == 0);
        end
    endfunction

    initial
    begin
        errors = 0;
        tgt_len = 0;
        qry_len = 0;
        ovf_flag = 1'b0;
        sc_match = 1;
        sc_mis = -4;
        sc_open = -6;
        sc_ext = -1;
        for (int a = 0; a <= MAXL; a++)
            for (int b = 0; b <= MAXL; b++)
            begin
                tm[a][b] = 0;
                ti[a][b] = 0;
                td[a][b] = 0;
            end
    end

    assign pending = run_q.size();

    always @(posedge clk)
    begin
        cigar_run_t e;
        if (rst_n)
        begin
            // Track register writes
            if (cfg_wr_en)
                case (cfg_addr)
                    REG_MATCH:    sc_match = $signed(cfg_wdata);
                    REG_MISMATCH: sc_mis   = $signed(cfg_wdata);
                    REG_GAP_OPEN: sc_open  = $signed(cfg_wdata);
                    REG_GAP_EXT:  sc_ext   = $signed(cfg_wdata);
                    default: ;
                endcase
            // Apply each command transfer
            if (cmd.valid && cmd.ready)
                case (cmd.opcode)
                    OPC_TARGET:
                        if (tgt_len < MAXL) tgt_seq[tgt_len++] = cmd.symbol;
                        else ovf_flag = 1'b1;
                    OPC_QUERY:
                        if (qry_len < MAXL) qry_seq[qry_len++] = cmd.symbol;
                        else ovf_flag = 1'b1;
                    OPC_ALIGN:
                    begin
                        align_runs();
                        tgt_len = 0;
                        qry_len = 0;
                        ovf_flag = 1'b0;
                    end
                    default: ;
                endcase
            // Compare each result transfer with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (run_q.size() == 0)
                begin
                    $error("unexpected result transfer op=%0d len=%0d",
                           result.cigar_op, result.run_length);
                    errors++;
                end
                else
                begin
                    e = run_q.pop_front();
                    if (result.cigar_op !== e.op)
                    begin
                        $error("cigar_op expected %0d actual %0d", e.op, result.cigar_op);
                        errors++;
                    end
                    if (result.run_length !== e.len)
                    begin
                        $error("run_length expected %0d actual %0d", e.len, result.run_length);
                        errors++;
                    end
                    if (result.total_score !== e.score)
                    begin
                        $error("total_score expected %0d actual %0d",
                               $signed(e.score), result.total_score);
                        errors++;
                    end
                    if (result.overflow !== e.ovf)
                    begin
                        $error("overflow expected %0d actual %0d", e.ovf, result.overflow);
                        errors++;
                    end
                    if (result.last !== e.last)
                    begin
                        $error("last expected %0d actual %0d", e.last, result.last);
                        errors++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
// Top of the aligner testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import aga_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    int errors;
    int pending;
    int send_idle;
    int recv_stall;
    int sent;
    int hold_cnt;
    logic hold_tgl;
    logic hold_seen;

    aga_in_if  cmd ();
    aga_out_if result ();

    affine_gap_global_aligner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    aga_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    // Stall the result side at random; a toggle of hold_tgl starts a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_tgl != hold_seen)
        begin
            hold_seen <= hold_tgl;
            hold_cnt <= 600;
            result.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Offer one command and hold it until transferred
    task automatic send(logic [OPC_W-1:0] opc, logic [SYM_W-1:0] sym);
        if ($urandom_range(99) < send_idle)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.opcode <= opc;
        cmd.symbol <= sym;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        sent++;
    endtask

    // Drain all results, then let the block settle
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_scores(logic [7:0] m, logic [7:0] mm, logic [7:0] go, logic [7:0] ge);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_MATCH;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_addr <= REG_MISMATCH;
        cfg_wdata <= mm;
        @(posedge clk);
        cfg_addr <= REG_GAP_OPEN;
        cfg_wdata <= go;
        @(posedge clk);
        cfg_addr <= REG_GAP_EXT;
        cfg_wdata <= ge;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SYM_W-1:0] pick_sym(bit narrow);
        return narrow ? SYM_W'($urandom_range(3)) : SYM_W'($urandom_range(255));
    endfunction

    // Load a target and a query interleaved at random, then align
    task automatic pair(int tl, int ql, bit narrow);
        int a, b;
        a = 0;
        b = 0;
        while (a < tl || b < ql)
        begin
            if (b >= ql || (a < tl && $urandom_range(1)))
            begin
                send(OPC_TARGET, pick_sym(narrow));
                a++;
            end
            else
            begin
                send(OPC_QUERY, pick_sym(narrow));
                b++;
            end
        end
        send(OPC_ALIGN, SYM_W'($urandom_range(255)));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 5) return $urandom_range(33, 36);
        if (r < 10) return 32;
        if (r < 15) return 0;
        return $urandom_range(1, 10);
    endfunction

    // Random stretch: mostly complete pairs, some stray items
    task automatic random_part(int count);
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(99) < 85)
                pair(pick_len(), pick_len(), $urandom_range(99) < 60);
            else
                send(OPC_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
        end
        send(OPC_ALIGN, 8'h00);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.opcode = OPC_TARGET;
        cmd.symbol = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_MATCH;
        cfg_wdata = '0;
        hold_tgl = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_scores(8'sd1, -8'sd4, -8'sd6, -8'sd1);

        // Directed: empty sequences, one-sided gaps, ignored opcode, symbol extremes
        send(OPC_ALIGN, 8'hff);
        pair(3, 0, 0);
        pair(0, 2, 0);
        send(2'd3, 8'h5a);
        send(OPC_TARGET, 8'h00);
        send(OPC_QUERY, 8'h00);
        send(OPC_TARGET, 8'hff);
        send(OPC_QUERY, 8'hff);
        send(OPC_TARGET, 8'hff);
        send(OPC_QUERY, 8'h00);
        send(OPC_ALIGN, 8'h00);
        pair(2, 4, 1);
        pair(1, 1, 1);

        // No idling, extreme scores
        set_scores(8'sd127, -8'sd128, -8'sd128, -8'sd128);
        random_part(30);

        // Sender mostly idle; long result hold-off while the block fills
        set_scores(-8'sd128, 8'sd127, 8'sd127, 8'sd127);
        send_idle = 85;
        hold_tgl <= ~hold_tgl;
        pair(32, 32, 1);
        pair(4, 3, 1);
        random_part(25);

        // Receiver mostly stalling, neutral scores
        set_scores(8'sd0, 8'sd0, 8'sd0, 8'sd0);
        send_idle = 0;
        recv_stall = 85;
        random_part(30);

        // Both sides idling at times, random scores
        set_scores(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
        send_idle = 21;
        recv_stall = 21;
        random_part(30);

        set_scores(8'sd2, -8'sd3, -8'sd5, -8'sd2);
        send_idle = 0;
        recv_stall = 0;
        hold_tgl <= ~hold_tgl;
        pair(32, 32, 0);
        pair(5, 6, 1);
        random_part(20);

        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
